// ===== rtl/aes_pkg.sv =====
// AES-128 package: S-box tables, GF(2^8) helpers, FSM state type.
// Used by aes128_block_cipher_unit; no dependencies.
`default_nettype none
package aes_pkg;

  localparam int Rounds = 10;
  localparam int NumWords = 4 * (Rounds + 1);
  localparam int WordAw = $clog2(NumWords);

  localparam logic [1:0] CfgKeyHigh = 2'd0;
  localparam logic [1:0] CfgKeyLow  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_t;

  function automatic logic [7:0] sbox(input logic [7:0] v);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[v];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] v);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[v];
  endfunction

  // round constant for key word group g (1..10)
  function automatic logic [7:0] rcon(input logic [3:0] g);
    logic [7:0] r;
    unique case (g)
      4'd1: r = 8'h01;
      4'd2: r = 8'h02;
      4'd3: r = 8'h04;
      4'd4: r = 8'h08;
      4'd5: r = 8'h10;
      4'd6: r = 8'h20;
      4'd7: r = 8'h40;
      4'd8: r = 8'h80;
      4'd9: r = 8'h1b;
      4'd10: r = 8'h36;
      default: r = 8'h8d;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // one column of MixColumns
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24];
    a1 = c[23:16];
    a2 = c[15:8];
    a3 = c[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  // one column of InvMixColumns (14,11,13,9)
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    a[0] = c[31:24];
    a[1] = c[23:16];
    a[2] = c[15:8];
    a[3] = c[7:0];
    for (int k = 0; k < 4; k++) begin
      x2[k] = xt(a[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [7:0] b [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        o[127-8*(r+4*c) -: 8] = sbox(b[r + 4*((c + r) % 4)]);
    return o;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [7:0] b [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        o[127-8*(r+4*((c + r) % 4)) -: 8] = inv_sbox(b[r + 4*c]);
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aes128_block_cipher_unit.sv =====
// AES-128 ECB core: key expansion into a round-key memory, shared round unit.
// Depends on aes_pkg.
// Flow: after the input transfer the block is loaded (initial key XOR), runs
// the 10 rounds, then is handed to the output register; the next block is taken in idle.
// The output register lets a new block start while a result waits; a finished
// block holds in the round unit until the output register frees.
// Key write: input stalled that cycle, then through an idle step and the expansion steps (words 4 to 43).
// Reset (rst, synchronous): FSM idle, no result pending; round-key memory holds
// whatever was last expanded and is defined only after a key write.
`default_nettype none
module aes128_block_cipher_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [63:0] data_high,
  input  wire logic [63:0] data_low,
  input  wire logic        last_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_high,
  output logic [63:0]      out_low,
  output logic             out_last
);

  localparam int Aw = aes_pkg::WordAw;
  localparam logic [Aw-1:0] LastWord = Aw'(aes_pkg::NumWords - 1);

  // Round keys: word memory (encrypt form) and a decrypt-form copy,
  // each four words wide per row, one row for the initial key and one per round.
  localparam int Rows = aes_pkg::Rounds + 1;
  localparam int Rw = $clog2(Rows);
  logic [127:0] rk_enc [Rows];
  logic [127:0] rk_dec [Rows];

  logic [63:0] key_high, key_low;
  aes_pkg::state_t state, state_next;

  // expansion: four-word sliding window in registers
  logic [Aw-1:0]  widx;
  logic [127:0]   win;
  logic [Rw-1:0]  rd_row;
  logic [127:0]   rd_enc, rd_dec;
  logic [127:0]   st;
  logic           dec;
  logic           last_q;
  logic [3:0]     round_counter;
  logic           expand_pend;

  // next expansion word
  logic [31:0] prev, tw, nw;
  always_comb begin
    prev = win[31:0];
    if (widx[1:0] == 2'd0) begin
      tw = {aes_pkg::sbox(prev[23:16]) ^ aes_pkg::rcon(widx[Aw-1:2]),
            aes_pkg::sbox(prev[15:8]), aes_pkg::sbox(prev[7:0]),
            aes_pkg::sbox(prev[31:24])};
    end else begin
      tw = prev;
    end
    nw = win[127:96] ^ tw;
  end

  // decrypt-form row: InvMixColumns on inner rounds
  logic [127:0] row_new, row_dec;
  logic [Rw-1:0] row_idx;
  always_comb begin
    row_new = {win[95:0], nw};
    row_idx = Rw'(widx[Aw-1:2]);
    if (row_idx == Rw'(aes_pkg::Rounds)) begin
      row_dec = row_new;
    end else begin
      row_dec = {aes_pkg::inv_mix_col(row_new[127:96]), aes_pkg::inv_mix_col(row_new[95:64]),
                 aes_pkg::inv_mix_col(row_new[63:32]), aes_pkg::inv_mix_col(row_new[31:0])};
    end
  end

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_we) begin
      if (cfg_index == aes_pkg::CfgKeyHigh) key_high <= cfg_data;
      if (cfg_index == aes_pkg::CfgKeyLow) key_low <= cfg_data;
    end
  end

  // single write port: row 0 from the key, then one row per four words
  logic mem_we;
  logic [127:0] row0;
  logic [Rw-1:0] mem_row;
  logic [127:0] mem_enc, mem_dec;
  assign row0 = {key_high, key_low};
  always_comb begin
    if (widx == Aw'(4)) begin
      mem_row = '0;
      mem_enc = row0;
      mem_dec = row0;
    end else begin
      mem_row = row_idx;
      mem_enc = row_new;
      mem_dec = row_dec;
    end
  end

  // memory writes and synchronous reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rk_enc[mem_row] <= mem_enc;
      rk_dec[mem_row] <= mem_dec;
    end
    rd_enc <= rk_enc[rd_row];
    rd_dec <= rk_dec[rd_row];
  end
  assign mem_we = (state == aes_pkg::ST_EXPAND) &&
                  (widx == Aw'(4) || widx[1:0] == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) expand_pend <= 1'b0;
    else if (cfg_we && (cfg_index == aes_pkg::CfgKeyHigh || cfg_index == aes_pkg::CfgKeyLow))
      expand_pend <= 1'b1;
    else if (state == aes_pkg::ST_IDLE) expand_pend <= 1'b0;
  end

  // FSM
  always_ff @(posedge clk) begin
    if (rst) state <= aes_pkg::ST_IDLE;
    else state <= state_next;
  end

  logic in_xfer, out_xfer, out_load;
  assign in_xfer = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign out_load = (state == aes_pkg::ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    unique case (state)
      aes_pkg::ST_IDLE: begin
        in_stall = expand_pend || cfg_we;
        if (expand_pend) state_next = aes_pkg::ST_EXPAND;
        else if (in_xfer) state_next = aes_pkg::ST_LOAD;
      end
      aes_pkg::ST_EXPAND: if (widx == LastWord) state_next = aes_pkg::ST_IDLE;
      aes_pkg::ST_LOAD: state_next = aes_pkg::ST_ROUND;
      aes_pkg::ST_ROUND:
        if (round_counter == 4'(aes_pkg::Rounds)) state_next = aes_pkg::ST_DONE;
      aes_pkg::ST_DONE: if (out_load) state_next = aes_pkg::ST_IDLE;
      default: state_next = aes_pkg::ST_IDLE;
    endcase
  end

  // expansion window: words 0..3 from key, then one word a cycle
  always_ff @(posedge clk) begin
    if (state == aes_pkg::ST_IDLE) begin
      widx <= Aw'(4);
      win <= row0;
    end else if (state == aes_pkg::ST_EXPAND) begin
      widx <= widx + Aw'(1);
      win <= row_new;
    end
  end

  // read row: encrypt rounds ascend, decrypt rounds descend
  logic [3:0] rnd_next;
  always_comb begin
    if (state == aes_pkg::ST_IDLE) rnd_next = 4'd0;
    else rnd_next = round_counter + 4'd1;
    if (state == aes_pkg::ST_IDLE ? func : dec)
      rd_row = Rw'(4'(aes_pkg::Rounds) - rnd_next);
    else
      rd_row = Rw'(rnd_next);
  end

  // round datapath
  logic [127:0] rk, t, mc;
  logic final_rnd;
  always_comb begin
    rk = dec ? rd_dec : rd_enc;
    final_rnd = round_counter == 4'(aes_pkg::Rounds);
    if (!dec) begin
      t = aes_pkg::sub_shift(st);
      if (final_rnd) mc = t;
      else mc = {aes_pkg::mix_col(t[127:96]), aes_pkg::mix_col(t[95:64]),
                 aes_pkg::mix_col(t[63:32]), aes_pkg::mix_col(t[31:0])};
    end else begin
      t = aes_pkg::inv_shift_sub(st);
      if (final_rnd) mc = t;
      else mc = {aes_pkg::inv_mix_col(t[127:96]), aes_pkg::inv_mix_col(t[95:64]),
                 aes_pkg::inv_mix_col(t[63:32]), aes_pkg::inv_mix_col(t[31:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_counter <= '0;
    end else if (state == aes_pkg::ST_LOAD) begin
      round_counter <= 4'd1;
    end else if (state == aes_pkg::ST_ROUND) begin
      round_counter <= final_rnd ? 4'd0 : round_counter + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      dec <= 1'b0;
      last_q <= 1'b0;
    end else if (in_xfer) begin
      st <= {data_high, data_low};
      dec <= func;
      last_q <= last_block;
    end else if (state == aes_pkg::ST_LOAD) begin
      st <= st ^ rk;
    end else if (state == aes_pkg::ST_ROUND) begin
      st <= mc ^ rk;
    end
  end

  // output register: takes the finished block when empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_high <= '0;
      out_low <= '0;
      out_last <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_high <= st[127:64];
      out_low <= st[63:0];
      out_last <= last_q;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aes128_block_cipher_unit_chk.sv =====
// Port-level checker for aes128_block_cipher_unit, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module aes128_block_cipher_unit_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_high,
  input wire logic [63:0] out_low
);

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_high) && $stable(out_low))
    else $error("stalled result changed");

  // no block taken in a key write cycle
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> in_stall)
    else $error("input taken during key write");

  // handshake outputs always known outside reset
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({out_valid, in_stall}))
    else $error("handshake output unknown");

endmodule

bind aes128_block_cipher_unit aes128_block_cipher_unit_chk u_chk (.*);
`default_nettype wire
